// ===== design/qspe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qspe_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CW               = 48;   // coefficient width, units of 2^-17
	localparam int ACCW             = 60;   // Horner accumulator width

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_EVAL  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_EVAL  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic        [23:0] param_u;
		logic        [2:0]  order;
	} item_t;

	// i!/(i-k)! for derivative order k and term i
	function automatic logic [6:0] deriv_scale(input logic [2:0] k, input logic [2:0] i);
		logic [6:0] s;
		s = 7'd0;
		unique case (k)
			3'd0: s = 7'd1;
			3'd1: s = (i >= 3'd1) ? 7'(i) : 7'd0;
			3'd2: unique case (i)
				3'd2: s = 7'd2;
				3'd3: s = 7'd6;
				3'd4: s = 7'd12;
				3'd5: s = 7'd20;
				default: s = 7'd0;
			endcase
			3'd3: unique case (i)
				3'd3: s = 7'd6;
				3'd4: s = 7'd24;
				3'd5: s = 7'd60;
				default: s = 7'd0;
			endcase
			3'd4: unique case (i)
				3'd4: s = 7'd24;
				3'd5: s = 7'd120;
				default: s = 7'd0;
			endcase
			default: s = 7'd0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== design/quintic_spline_path_evaluator_top.sv =====
// Piecewise quintic Hermite path evaluator. Push waypoints (mode 0), evaluate
// queries (mode 1, param_u in Q8.16 plus derivative order) or clears (mode 2)
// into a two-entry input queue; each item yields exactly one result popped
// from the output side. A waypoint that adds a segment passes an intake step in
// the back end and then writes one coefficient per cycle into the single-port
// table. An evaluate runs each Horner term per axis through a multiply-low,
// multiply-high and add step on one shared multiplier, with 6-order terms per
// axis after intake. Other items go straight from intake to the result.
// Results are Q16.16, saturated; status 1 flags an evaluate on an empty path,
// status 2 a dropped waypoint because the table holds MAX_SEGMENTS segments.
`timescale 1ns / 1ps
`default_nettype none
module quintic_spline_path_evaluator_top #(
	parameter int MAX_SEGMENTS = qspe_pkg::MAX_SEGMENTS_DEF,
	parameter int FRAC_BITS    = qspe_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic [1:0]         mode,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] vel_x,
	input  wire logic signed [31:0] vel_y,
	input  wire logic signed [31:0] acc_x,
	input  wire logic signed [31:0] acc_y,
	input  wire logic [23:0]        param_u,
	input  wire logic [2:0]         order,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic [1:0]              status
);

	logic            q_valid, q_take;
	qspe_pkg::item_t q_item;

	qspe_front u_front (
		.clk, .arst_n, .push, .full, .mode,
		.pos_x, .pos_y, .vel_x, .vel_y, .acc_x, .acc_y, .param_u, .order,
		.q_valid, .q_item, .q_take
	);

	qspe_back #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.FRAC_BITS   (FRAC_BITS)
	) u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_take,
		.empty, .pop, .out_x, .out_y, .status
	);

endmodule
`default_nettype wire

// ===== design/qspe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qspe_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	output logic                      full,
	input  wire logic [1:0]           mode,
	input  wire logic signed [31:0]   pos_x,
	input  wire logic signed [31:0]   pos_y,
	input  wire logic signed [31:0]   vel_x,
	input  wire logic signed [31:0]   vel_y,
	input  wire logic signed [31:0]   acc_x,
	input  wire logic signed [31:0]   acc_y,
	input  wire logic [23:0]          param_u,
	input  wire logic [2:0]           order,
	output logic                      q_valid,
	output qspe_pkg::item_t           q_item,
	input  wire logic                 q_take
);

	qspe_pkg::item_t ent_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	qspe_pkg::item_t in_item;
	logic            do_wr, do_rd;

	always_comb begin
		in_item = '0;
		unique case (mode)
			qspe_pkg::MODE_ADD:   in_item.op = qspe_pkg::OP_ADD;
			qspe_pkg::MODE_EVAL:  in_item.op = qspe_pkg::OP_EVAL;
			qspe_pkg::MODE_CLEAR: in_item.op = qspe_pkg::OP_CLEAR;
			default:              in_item.op = qspe_pkg::OP_NOP;
		endcase
		in_item.pos_x   = pos_x;
		in_item.pos_y   = pos_y;
		in_item.vel_x   = vel_x;
		in_item.vel_y   = vel_y;
		in_item.acc_x   = acc_x;
		in_item.acc_y   = acc_y;
		in_item.param_u = param_u;
		in_item.order   = order;
	end

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_item  = ent_q[rd_ptr_q];
	assign do_wr   = push && !full;
	assign do_rd   = q_take && q_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

endmodule
`default_nettype wire

// ===== design/qspe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qspe_back #(
	parameter int MAX_SEGMENTS = qspe_pkg::MAX_SEGMENTS_DEF,
	parameter int FRAC_BITS    = qspe_pkg::FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire qspe_pkg::item_t    q_item,
	output logic                    q_take,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic [1:0]              status
);

	localparam int CW    = qspe_pkg::CW;
	localparam int ACCW  = qspe_pkg::ACCW;
	localparam int DEPTH = MAX_SEGMENTS * 12;
	localparam int ADDRW = $clog2(DEPTH);
	localparam int CNTW  = $clog2(MAX_SEGMENTS + 1);
	localparam int TW    = FRAC_BITS + 1;
	localparam int PW    = 31 + TW + 1;
	localparam int SW    = PW + 30;
	localparam int SCW   = CW + 8;

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_WRITE = 6'b000010,
		B_M1    = 6'b000100,
		B_M2    = 6'b001000,
		B_ADD   = 6'b010000,
		B_OUT   = 6'b100000
	} bstate_t;

	bstate_t                state_q;
	qspe_pkg::item_t        item_q;
	logic signed [31:0]     st_q [6];   // px, py, vx, vy, ax, ay
	logic                   have_start_q;
	logic [CNTW-1:0]        count_q;
	logic [CNTW-1:0]        seg_q;
	logic [TW-1:0]          t_q;
	logic                   axis_q;
	logic [2:0]             term_q;
	logic signed [ACCW-1:0] acc_q;
	logic signed [PW-1:0]   lo_q, hi_q;
	logic signed [SCW-1:0]  sc_q;
	logic signed [CW-1:0]   rd_q;
	logic signed [31:0]     res_x_q, res_y_q;
	logic [1:0]             res_st_q;

	logic signed [CW-1:0]   mem [DEPTH];

	// evaluate setup
	logic [24:0]            idx;
	logic [24:0]            t_raw;
	logic                   past_end;

	assign idx      = {1'b0, q_item.param_u} >> FRAC_BITS;
	assign t_raw    = {1'b0, q_item.param_u} & ((25'd1 << FRAC_BITS) - 25'd1);
	assign past_end = (idx >= 25'(count_q));

	// table address of the current term
	logic [ADDRW-1:0] addr;
	assign addr = ADDRW'(ADDRW'(seg_q) * ADDRW'(4'd12) + (axis_q ? ADDRW'(3'd6) : ADDRW'(0))
		+ ADDRW'(term_q));

	// coefficient build for the current axis and term
	logic signed [CW-1:0] p0, v0, a0, p1, v1, a1, coef;
	always_comb begin
		p0 = {{(CW-32){st_q[{2'b00, axis_q}][31]}}, st_q[{2'b00, axis_q}]};
		v0 = {{(CW-32){st_q[{2'b01, axis_q}][31]}}, st_q[{2'b01, axis_q}]};
		a0 = {{(CW-32){st_q[{2'b10, axis_q}][31]}}, st_q[{2'b10, axis_q}]};
		p1 = axis_q ? {{(CW-32){item_q.pos_y[31]}}, item_q.pos_y}
		            : {{(CW-32){item_q.pos_x[31]}}, item_q.pos_x};
		v1 = axis_q ? {{(CW-32){item_q.vel_y[31]}}, item_q.vel_y}
		            : {{(CW-32){item_q.vel_x[31]}}, item_q.vel_x};
		a1 = axis_q ? {{(CW-32){item_q.acc_y[31]}}, item_q.acc_y}
		            : {{(CW-32){item_q.acc_x[31]}}, item_q.acc_x};
		unique case (term_q)
			3'd0: coef = p0 + p0;
			3'd1: coef = v0 + v0;
			3'd2: coef = a0;
			3'd3: coef = CW'(20) * (p1 - p0) - CW'(12) * v0 - CW'(8) * v1
				- CW'(3) * a0 + a1;
			3'd4: coef = CW'(30) * (p0 - p1) + CW'(16) * v0 + CW'(14) * v1
				+ CW'(3) * a0 - CW'(2) * a1;
			3'd5: coef = CW'(12) * (p1 - p0) - CW'(6) * (v0 + v1) + a1 - a0;
			default: coef = '0;
		endcase
	end

	// shared multiplier: low 30 bits of acc in B_M1, signed upper 30 in B_M2
	logic signed [30:0] mul_a;
	logic signed [PW-1:0] prod;
	assign mul_a = (state_q == B_M1) ? {1'b0, acc_q[29:0]}
	                                 : {acc_q[ACCW-1], acc_q[ACCW-1 -: 30]};
	assign prod  = PW'(mul_a) * PW'($signed({1'b0, t_q}));

	// floor(acc * t / 2^F) + scaled term
	logic signed [SW-1:0]   psum;
	logic signed [ACCW-1:0] acc_new;
	logic signed [ACCW-1:0] half;
	logic signed [31:0]     sat;
	assign psum    = {hi_q, 30'b0} + {{30{lo_q[PW-1]}}, lo_q};
	assign acc_new = ACCW'(psum >>> FRAC_BITS) + {{(ACCW-SCW){sc_q[SCW-1]}}, sc_q};
	assign half    = acc_new >>> 1;
	always_comb begin
		if (half > ACCW'(64'sd2147483647)) begin
			sat = 32'sh7FFFFFFF;
		end else if (half < -ACCW'(64'sd2147483648)) begin
			sat = 32'sh80000000;
		end else begin
			sat = half[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_WRITE) begin
			mem[addr] <= coef;
		end
		if (state_q == B_M1) begin
			rd_q <= mem[addr];
		end
	end

	assign q_take = (state_q == B_IDLE);
	assign empty  = (state_q != B_OUT);
	assign out_x  = res_x_q;
	assign out_y  = res_y_q;
	assign status = res_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			have_start_q <= 1'b0;
			count_q      <= '0;
			for (int n = 0; n < 6; n++) st_q[n] <= '0;
			item_q   <= '0;
			seg_q    <= '0;
			t_q      <= '0;
			axis_q   <= 1'b0;
			term_q   <= '0;
			acc_q    <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			sc_q     <= '0;
			res_x_q  <= '0;
			res_y_q  <= '0;
			res_st_q <= qspe_pkg::ST_OK;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						item_q   <= q_item;
						res_x_q  <= '0;
						res_y_q  <= '0;
						res_st_q <= qspe_pkg::ST_OK;
						axis_q   <= 1'b0;
						acc_q    <= '0;
						state_q  <= B_OUT;
						unique case (q_item.op)
							qspe_pkg::OP_ADD: begin
								if (!have_start_q) begin
									have_start_q <= 1'b1;
									st_q[0] <= q_item.pos_x;
									st_q[1] <= q_item.pos_y;
									st_q[2] <= q_item.vel_x;
									st_q[3] <= q_item.vel_y;
									st_q[4] <= q_item.acc_x;
									st_q[5] <= q_item.acc_y;
								end else if (count_q >= CNTW'(MAX_SEGMENTS)) begin
									res_st_q <= qspe_pkg::ST_FULL;
								end else begin
									seg_q   <= count_q;
									term_q  <= 3'd0;
									state_q <= B_WRITE;
								end
							end
							qspe_pkg::OP_EVAL: begin
								if (count_q == '0) begin
									res_st_q <= qspe_pkg::ST_EMPTY;
								end else if (q_item.order <= 3'd4) begin
									seg_q   <= past_end ? count_q - CNTW'(1) : CNTW'(idx);
									t_q     <= past_end ? TW'(1) << FRAC_BITS : TW'(t_raw);
									term_q  <= 3'd5;
									state_q <= B_M1;
								end
							end
							qspe_pkg::OP_CLEAR: begin
								have_start_q <= 1'b0;
								count_q      <= '0;
								for (int n = 0; n < 6; n++) st_q[n] <= '0;
							end
							default: ;
						endcase
					end
				end
				B_WRITE: begin
					if (term_q == 3'd5) begin
						term_q <= 3'd0;
						axis_q <= 1'b1;
						if (axis_q) begin
							count_q <= count_q + CNTW'(1);
							st_q[0] <= item_q.pos_x;
							st_q[1] <= item_q.pos_y;
							st_q[2] <= item_q.vel_x;
							st_q[3] <= item_q.vel_y;
							st_q[4] <= item_q.acc_x;
							st_q[5] <= item_q.acc_y;
							state_q <= B_OUT;
						end
					end else begin
						term_q <= term_q + 3'd1;
					end
				end
				B_M1: begin
					lo_q    <= prod;
					state_q <= B_M2;
				end
				B_M2: begin
					hi_q    <= prod;
					sc_q    <= SCW'(rd_q) * SCW'($signed({1'b0,
						qspe_pkg::deriv_scale(item_q.order, term_q)}));
					state_q <= B_ADD;
				end
				B_ADD: begin
					if (term_q == item_q.order) begin
						if (axis_q) begin
							res_y_q <= sat;
							state_q <= B_OUT;
						end else begin
							res_x_q <= sat;
							axis_q  <= 1'b1;
							term_q  <= 3'd5;
							acc_q   <= '0;
							state_q <= B_M1;
						end
					end else begin
						acc_q   <= acc_new;
						term_q  <= term_q - 3'd1;
						state_q <= B_M1;
					end
				end
				B_OUT: begin
					if (pop) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== design/qspe_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qspe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        push,
	input wire logic        full,
	input wire logic        pop,
	input wire logic        empty,
	input wire logic [31:0] out_x,
	input wire logic [31:0] out_y,
	input wire logic [1:0]  status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_x) && $stable(out_y) && $stable(status))
		else $error("result changed while waiting");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status != 2'd3)
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status != 2'd0 |-> out_x == 32'd0 && out_y == 32'd0)
		else $error("error result carries data");

	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && pop |=> empty)
		else $error("result repeated after transfer");

	// the input side can only fill up through a transfer
	a_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!push && !full |=> !full)
		else $error("full rose without a transfer");

endmodule

bind quintic_spline_path_evaluator_top qspe_checker u_qspe_checker (
	.clk(clk), .arst_n(arst_n), .push(push), .full(full), .pop(pop),
	.empty(empty), .out_x(out_x), .out_y(out_y), .status(status)
);
`default_nettype wire
